// ===== sv/rrpc_pkg.sv =====
// Shared constants and types for the rounded region point clamp.
// No dependencies; the other files, the checker apart, refer to this package by scoped names.
`default_nettype none
package rrpc_pkg;
    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 32;
    localparam int RADIUS_W    = 30;
    localparam int WIDE_W      = 62;
    localparam int PROD_W      = 60;
    localparam int SQRT_STAGES = 31;
    localparam int DIV_STAGES  = 30;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1 << FRAC_BITS);

    typedef struct packed {
        logic [COORD_W-1:0] def_u;
        logic [COORD_W-1:0] def_v;
        logic [COORD_W-1:0] cu;
        logic               use_arc;
        logic               at_centre;
        logic               neg_x;
        logic               neg_y;
        logic [PROD_W-1:0]  prod_x;
        logic [PROD_W-1:0]  prod_y;
    } t_side;
endpackage
`default_nettype wire

// ===== sv/rrpc_if.sv =====
// Valid/ready channel interfaces for input points and clamped results.
// Depends on rrpc_pkg for the coordinate width.
`default_nettype none
interface rrpc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rrpc_pkg::COORD_W-1:0]  point_u;
    logic signed [rrpc_pkg::COORD_W-1:0]  point_v;
    modport source(output valid, output point_u, output point_v, input ready);
    modport sink(input valid, input point_u, input point_v, output ready);
endinterface

interface rrpc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rrpc_pkg::COORD_W-1:0]  proj_u;
    logic signed [rrpc_pkg::COORD_W-1:0]  proj_v;
    modport source(output valid, output proj_u, output proj_v, input ready);
    modport sink(input valid, input proj_u, input proj_v, output ready);
endinterface
`default_nettype wire

// ===== sv/rrpc_front.sv =====
// Front end: region classification, products and squared distance (three stages).
// Depends on rrpc_pkg.
`default_nettype none
module rrpc_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_ce,
    input  wire logic                                i_valid,
    input  wire logic signed [rrpc_pkg::COORD_W-1:0] i_u,
    input  wire logic signed [rrpc_pkg::COORD_W-1:0] i_v,
    input  wire logic [rrpc_pkg::RADIUS_W-1:0]       i_radius,
    output logic                                     o_valid,
    output logic [rrpc_pkg::WIDE_W-1:0]              o_d2,
    output rrpc_pkg::t_side                          o_side
);
    logic signed [33:0] u34, v34, r34, cu34, x34, ax34, ay34;
    logic               left;
    logic [31:0]        n_def_u, n_def_v;
    logic               n_cand;

    logic                              r1_valid, r1_cand, r1_negx, r1_negy;
    logic [31:0]                       r1_def_u, r1_def_v, r1_cu;
    logic [rrpc_pkg::RADIUS_W-1:0]     r1_ax, r1_ay;

    logic                              r2_valid, r2_cand, r2_negx, r2_negy;
    logic [31:0]                       r2_def_u, r2_def_v, r2_cu;
    logic [rrpc_pkg::PROD_W-1:0]       r2_sqx, r2_sqy, r2_rr, r2_px, r2_py;
    logic [rrpc_pkg::PROD_W-1:0]       n_sqx, n_sqy, n_rr, n_px, n_py;

    logic [rrpc_pkg::PROD_W:0]         d2;
    logic                              in_circle;

    always_comb begin
        u34     = 34'(i_u);
        v34     = 34'(i_v);
        r34     = signed'({4'b0, i_radius});
        left    = i_u[31];
        cu34    = left ? -r34 : r34;
        x34     = u34 - cu34;
        ax34    = x34[33] ? -x34 : x34;
        ay34    = r34 - v34;
        n_cand  = 1'b0;
        n_def_u = i_u;
        n_def_v = i_v;
        priority if (left && (u34 < -r34)) begin
            n_def_u = cu34[31:0];
            n_def_v = '0;
        end else if (!left && (u34 > r34)) begin
            n_def_u = r34[31:0];
            n_def_v = '0;
        end else if (v34 > r34) begin
            n_def_u = '0;
            n_def_v = r34[31:0];
        end else if (i_v[31]) begin
            n_def_v = '0;
        end else begin
            n_cand = 1'b1;
        end
    end

    always_comb begin
        n_sqx = r1_ax * r1_ax;
        n_sqy = r1_ay * r1_ay;
        n_rr  = i_radius * i_radius;
        n_px  = i_radius * r1_ax;
        n_py  = i_radius * r1_ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_ce) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_def_u <= n_def_u;
            r1_def_v <= n_def_v;
            r1_cu    <= cu34[31:0];
            r1_cand  <= n_cand;
            r1_negx  <= x34[33];
            r1_negy  <= (ay34 != '0);
            r1_ax    <= ax34[rrpc_pkg::RADIUS_W-1:0];
            r1_ay    <= ay34[rrpc_pkg::RADIUS_W-1:0];
            r2_def_u <= r1_def_u;
            r2_def_v <= r1_def_v;
            r2_cu    <= r1_cu;
            r2_cand  <= r1_cand;
            r2_negx  <= r1_negx;
            r2_negy  <= r1_negy;
            r2_sqx   <= n_sqx;
            r2_sqy   <= n_sqy;
            r2_rr    <= n_rr;
            r2_px    <= n_px;
            r2_py    <= n_py;
        end
    end

    always_comb begin
        d2        = {1'b0, r2_sqx} + {1'b0, r2_sqy};
        in_circle = r2_cand && (d2 < {1'b0, r2_rr});
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_d2             <= rrpc_pkg::WIDE_W'(d2);
            o_side.def_u     <= r2_def_u;
            o_side.def_v     <= r2_def_v;
            o_side.cu        <= r2_cu;
            o_side.use_arc   <= in_circle && (d2 != '0);
            o_side.at_centre <= in_circle && (d2 == '0);
            o_side.neg_x     <= r2_negx;
            o_side.neg_y     <= r2_negy;
            o_side.prod_x    <= r2_px;
            o_side.prod_y    <= r2_py;
        end
    end
endmodule
`default_nettype wire

// ===== sv/rrpc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on rrpc_pkg.
`default_nettype none
module rrpc_sqrt (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_ce,
    input  wire logic                            i_valid,
    input  wire logic [rrpc_pkg::WIDE_W-1:0]     i_d2,
    input  wire rrpc_pkg::t_side                 i_side,
    output logic                                 o_valid,
    output logic [rrpc_pkg::RADIUS_W-1:0]        o_root,
    output rrpc_pkg::t_side                      o_side
);
    localparam int N = rrpc_pkg::SQRT_STAGES;
    localparam int W = rrpc_pkg::WIDE_W;

    logic [W-1:0]     r_n   [0:N-1];
    logic [W-1:0]     r_res [0:N-1];
    rrpc_pkg::t_side  r_side[0:N-1];
    logic [N-1:0]     r_valid;

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
        logic [W-1:0] n_in, res_in, sum, n_n, n_res;
        logic         v_in;
        rrpc_pkg::t_side s_in;

        if (k == 0) begin : g_first
            assign n_in   = i_d2;
            assign res_in = '0;
            assign v_in   = i_valid;
            assign s_in   = i_side;
        end else begin : g_next
            assign n_in   = r_n[k-1];
            assign res_in = r_res[k-1];
            assign v_in   = r_valid[k-1];
            assign s_in   = r_side[k-1];
        end

        always_comb begin
            sum = res_in + BIT;
            if (n_in >= sum) begin
                n_n   = n_in - sum;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_n   = n_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_ce) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_n[k]    <= n_n;
                r_res[k]  <= n_res;
                r_side[k] <= s_in;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_root  = r_res[N-1][rrpc_pkg::RADIUS_W-1:0];
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

// ===== sv/rrpc_div.sv =====
// Pipelined rounding divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on rrpc_pkg.
`default_nettype none
module rrpc_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_ce,
    input  wire logic                            i_valid,
    input  wire logic [rrpc_pkg::RADIUS_W-1:0]   i_root,
    input  wire rrpc_pkg::t_side                 i_side,
    output logic                                 o_valid,
    output logic [rrpc_pkg::RADIUS_W-1:0]        o_qx,
    output logic [rrpc_pkg::RADIUS_W-1:0]        o_qy,
    output rrpc_pkg::t_side                      o_side
);
    localparam int N = rrpc_pkg::DIV_STAGES;
    localparam int W = rrpc_pkg::WIDE_W;
    localparam int Q = rrpc_pkg::RADIUS_W;

    logic [W-1:0]     r_p_nx, r_p_ny;
    logic [Q:0]       r_p_d;
    logic             r_p_valid;
    rrpc_pkg::t_side  r_p_side;

    logic [W-1:0]     r_rx  [0:N-1];
    logic [W-1:0]     r_ry  [0:N-1];
    logic [Q-1:0]     r_qx  [0:N-1];
    logic [Q-1:0]     r_qy  [0:N-1];
    logic [Q:0]       r_d   [0:N-1];
    rrpc_pkg::t_side  r_side[0:N-1];
    logic [N-1:0]     r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_ce) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p_nx   <= {1'b0, i_side.prod_x, 1'b0} + W'(i_root);
            r_p_ny   <= {1'b0, i_side.prod_y, 1'b0} + W'(i_root);
            r_p_d    <= {i_root, 1'b0};
            r_p_side <= i_side;
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int SH = N - 1 - j;
        logic [W-1:0]    rx_in, ry_in, dsh, n_rx, n_ry;
        logic [Q-1:0]    qx_in, qy_in, n_qx, n_qy;
        logic [Q:0]      d_in;
        logic            v_in;
        rrpc_pkg::t_side s_in;

        if (j == 0) begin : g_first
            assign rx_in = r_p_nx;
            assign ry_in = r_p_ny;
            assign qx_in = '0;
            assign qy_in = '0;
            assign d_in  = r_p_d;
            assign v_in  = r_p_valid;
            assign s_in  = r_p_side;
        end else begin : g_next
            assign rx_in = r_rx[j-1];
            assign ry_in = r_ry[j-1];
            assign qx_in = r_qx[j-1];
            assign qy_in = r_qy[j-1];
            assign d_in  = r_d[j-1];
            assign v_in  = r_valid[j-1];
            assign s_in  = r_side[j-1];
        end

        always_comb begin
            dsh  = W'(d_in) << SH;
            n_rx = rx_in;
            n_ry = ry_in;
            n_qx = qx_in;
            n_qy = qy_in;
            if (rx_in >= dsh) begin
                n_rx     = rx_in - dsh;
                n_qx[SH] = 1'b1;
            end
            if (ry_in >= dsh) begin
                n_ry     = ry_in - dsh;
                n_qy[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_ce) begin
                r_valid[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rx[j]   <= n_rx;
                r_ry[j]   <= n_ry;
                r_qx[j]   <= n_qx;
                r_qy[j]   <= n_qy;
                r_d[j]    <= d_in;
                r_side[j] <= s_in;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_qx    = r_qx[N-1];
    assign o_qy    = r_qy[N-1];
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

// ===== sv/rrpc_out.sv =====
// Result assembly and two-entry output buffer; issues the pipeline advance.
// Depends on rrpc_pkg.
`default_nettype none
module rrpc_out (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [rrpc_pkg::RADIUS_W-1:0]   i_qx,
    input  wire logic [rrpc_pkg::RADIUS_W-1:0]   i_qy,
    input  wire rrpc_pkg::t_side                 i_side,
    input  wire logic [rrpc_pkg::RADIUS_W-1:0]   i_radius,
    input  wire logic                            i_ready,
    output logic                                 o_ce,
    output logic                                 o_valid,
    output logic [rrpc_pkg::COORD_W-1:0]         o_u,
    output logic [rrpc_pkg::COORD_W-1:0]         o_v
);
    localparam int C = rrpc_pkg::COORD_W;

    logic [C-1:0] r32, sx, sy, res_u, res_v;
    logic [2*C-1:0] r_buf [0:1];
    logic [1:0]   r_cnt;
    logic         r_head, tail, push, pop;

    always_comb begin
        r32 = C'(i_radius);
        sx  = i_side.neg_x ? -C'(i_qx) : C'(i_qx);
        sy  = i_side.neg_y ? -C'(i_qy) : C'(i_qy);
        priority if (i_side.use_arc) begin
            res_u = i_side.cu + sx;
            res_v = r32 + sy;
        end else if (i_side.at_centre) begin
            res_u = i_side.cu + r32;
            res_v = r32;
        end else begin
            res_u = i_side.def_u;
            res_v = i_side.def_v;
        end
    end

    assign o_ce    = (r_cnt != 2'd2);
    assign push    = o_ce && i_valid;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign tail    = r_head ^ r_cnt[0];
    assign o_u     = r_buf[r_head][2*C-1:C];
    assign o_v     = r_buf[r_head][C-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_head <= 1'b0;
        end else begin
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
            if (pop) begin
                r_head <= ~r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[tail] <= {res_u, res_v};
        end
    end
endmodule
`default_nettype wire

// ===== sv/rounded_region_point_clamp.sv =====
// Throughput: one point per cycle; 3 front stages, 31 square-root stages, 31 divider
// stages, then a two-entry output buffer whose fill is what stalls the pipeline.
// Reset (synchronous, active low) empties the pipeline and buffer and sets radius to 1.0.
// Depends on rrpc_pkg, rrpc_if and the rrpc_* stage modules.
`default_nettype none
module rounded_region_point_clamp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_radius_we,
    input  wire logic [rrpc_pkg::RADIUS_W-1:0] i_radius_wdata,
    rrpc_in_if.sink                            i_pt,
    rrpc_out_if.source                         o_proj
);
    logic [rrpc_pkg::RADIUS_W-1:0] r_radius;
    logic                          ce;
    logic                          f_valid, s_valid, d_valid;
    logic [rrpc_pkg::WIDE_W-1:0]   f_d2;
    logic [rrpc_pkg::RADIUS_W-1:0] s_root, d_qx, d_qy;
    rrpc_pkg::t_side               f_side, s_side, d_side;
    logic [rrpc_pkg::COORD_W-1:0]  out_u, out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= rrpc_pkg::RADIUS_RST;
        end else if (i_radius_we) begin
            r_radius <= i_radius_wdata;
        end
    end

    assign i_pt.ready = ce;

    rrpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce),
        .i_valid(i_pt.valid), .i_u(i_pt.point_u), .i_v(i_pt.point_v),
        .i_radius(r_radius),
        .o_valid(f_valid), .o_d2(f_d2), .o_side(f_side)
    );

    rrpc_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce),
        .i_valid(f_valid), .i_d2(f_d2), .i_side(f_side),
        .o_valid(s_valid), .o_root(s_root), .o_side(s_side)
    );

    rrpc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce),
        .i_valid(s_valid), .i_root(s_root), .i_side(s_side),
        .o_valid(d_valid), .o_qx(d_qx), .o_qy(d_qy), .o_side(d_side)
    );

    rrpc_out u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(d_valid), .i_qx(d_qx), .i_qy(d_qy), .i_side(d_side),
        .i_radius(r_radius), .i_ready(o_proj.ready),
        .o_ce(ce), .o_valid(o_proj.valid), .o_u(out_u), .o_v(out_v)
    );

    assign o_proj.proj_u = out_u;
    assign o_proj.proj_v = out_v;
endmodule
`default_nettype wire

// ===== sv/rrpc_checker.sv =====
// Port-level checks on the point clamp, bound to the top level.
// Depends on rounded_region_point_clamp port names only.
`default_nettype none
module rrpc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_proj_u,
    input wire logic [31:0] i_proj_v
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_proj_u) && $stable(i_proj_v))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input held off with no result waiting");

    a_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> !$isunknown(i_in_ready))
        else $error("input ready unknown while a point is offered");
endmodule

bind rounded_region_point_clamp rrpc_checker u_rrpc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_pt.valid), .i_in_ready(i_pt.ready),
    .i_out_valid(o_proj.valid), .i_out_ready(o_proj.ready),
    .i_proj_u(o_proj.proj_u), .i_proj_v(o_proj.proj_v)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for rounded_region_point_clamp: drives points, predicts clamps.
// Depends on rrpc_pkg, the rrpc_in_if/rrpc_out_if interfaces and the block's RTL.
`timescale 1ns / 100ps

typedef struct {
    logic signed [rrpc_pkg::COORD_W-1:0] u;
    logic signed [rrpc_pkg::COORD_W-1:0] v;
} point_t;

class clamp_board;
    logic [rrpc_pkg::RADIUS_W-1:0] radius = rrpc_pkg::RADIUS_RST;
    point_t expected_q[$];
    int mismatches = 0;
    int checked = 0;

    function longint unsigned root(longint unsigned n);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function longint scaled(longint unsigned r, longint off, longint unsigned d);
        longint unsigned mag = (off < 0) ? -off : off;
        longint unsigned q = (2 * r * mag + d) / (2 * d);
        return (off < 0) ? -longint'(q) : longint'(q);
    endfunction

    function point_t clamp(logic signed [31:0] pu, logic signed [31:0] pv);
        longint u = pu;
        longint v = pv;
        longint r = longint'(radius);
        longint cu, x, y, ru, rv;
        longint unsigned ax, ay, d2, r2, d;
        bit left = (u < 0);
        point_t p;
        if (left && u < -r) begin
            ru = -r; rv = 0;
        end else if (!left && u > r) begin
            ru = r; rv = 0;
        end else if (v > r) begin
            ru = 0; rv = r;
        end else if (v < 0) begin
            ru = u; rv = 0;
        end else begin
            cu = left ? -r : r;
            x = u - cu;
            y = v - r;
            ax = (x < 0) ? -x : x;
            ay = -y;
            d2 = ax * ax + ay * ay;
            r2 = r * r;
            ru = u; rv = v;
            if (d2 < r2) begin
                if (d2 == 0) begin
                    ru = cu + r; rv = r;
                end else begin
                    d = root(d2);
                    ru = cu + scaled(r, x, d);
                    rv = r + scaled(r, y, d);
                end
            end
        end
        p.u = ru[31:0];
        p.v = rv[31:0];
        return p;
    endfunction

    function void note_point(logic signed [31:0] u, logic signed [31:0] v);
        expected_q = {expected_q, clamp(u, v)};
    endfunction

    function void check_result(logic signed [31:0] u, logic signed [31:0] v);
        point_t e;
        checked++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result (%0d,%0d)", u, v);
            return;
        end
        e = expected_q.pop_front();
        if (e.u !== u || e.v !== v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch R=%0d: expected (%0d,%0d) got (%0d,%0d)",
                         radius, e.u, e.v, u, v);
        end
    endfunction
endclass

module testbench;
    localparam int LIMIT = 600000;
    localparam int DRAIN = 80;
    localparam int PER_PHASE = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_radius_we = 1'b0;
    logic [rrpc_pkg::RADIUS_W-1:0] i_radius_wdata = '0;

    rrpc_in_if pt_ch();
    rrpc_out_if proj_ch();

    rounded_region_point_clamp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_radius_we(i_radius_we), .i_radius_wdata(i_radius_wdata),
        .i_pt(pt_ch.sink), .o_proj(proj_ch.source)
    );

    clamp_board board = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cnt = 0;
    bit hold_req = 1'b0;
    int cycles = 0;
    int sent = 0;

    always #2 i_clk = ~i_clk;

    initial begin
        pt_ch.valid = 1'b0;
        pt_ch.point_u = '0;
        pt_ch.point_v = '0;
        proj_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_cnt = 400;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            proj_ch.ready <= 1'b0;
        end else begin
            proj_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && proj_ch.valid && proj_ch.ready)
            board.check_result(proj_ch.proj_u, proj_ch.proj_v);
    end

    task automatic send_point(logic signed [31:0] u, logic signed [31:0] v);
        while ($urandom_range(99) < send_idle) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.point_u <= u;
        pt_ch.point_v <= v;
        do @(posedge i_clk); while (!pt_ch.ready);
        board.note_point(u, v);
        sent++;
    endtask

    task automatic drain();
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [rrpc_pkg::RADIUS_W-1:0] r);
        drain();
        i_radius_we <= 1'b1;
        i_radius_wdata <= r;
        @(posedge i_clk);
        i_radius_we <= 1'b0;
        board.radius = r;
    endtask

    task automatic directed_points();
        logic signed [31:0] r = 32'(board.radius);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(-r - 1, r / 2);
        send_point(r + 1, r / 2);
        send_point(0, r + 1);
        send_point(r / 3, -1);
        send_point(-r, r);
        send_point(r, r);
        send_point(-r / 2, r / 2);
        send_point(r / 2, r / 2);
        send_point(-r + 1, r - 1);
        send_point(r - 1, r - 3);
        send_point(0, r);
        send_point(0, 0);
        send_point(0, -5);
        send_point(0, 5);
        send_point(-1, 0);
        send_point(1, 0);
        send_point(-r, 0);
        send_point(r, 0);
    endtask

    function automatic void pick_point(output logic signed [31:0] u,
                                       output logic signed [31:0] v);
        longint r = longint'(board.radius);
        longint a, b;
        int kind = $urandom_range(9);
        if (kind < 2) begin
            u = $urandom; v = $urandom;
            return;
        end
        if (kind < 8) begin
            a = longint'($urandom_range(32'(2 * r))) - r;
            b = longint'($urandom_range(32'(r)));
        end else if (kind == 8) begin
            a = ($urandom_range(1) ? r : -r) + longint'($urandom_range(16)) - 8;
            b = r - longint'($urandom_range(16));
        end else begin
            a = ($urandom_range(1) ? r : -r) + longint'($urandom_range(4)) - 2;
            b = longint'($urandom_range(32'(r + 2))) - 1;
        end
        u = a[31:0];
        v = b[31:0];
    endfunction

    task automatic random_points(int n);
        logic signed [31:0] u, v;
        repeat (n) begin
            pick_point(u, v);
            send_point(u, v);
        end
    endtask

    initial begin
        logic [rrpc_pkg::RADIUS_W-1:0] radii[6];
        radii = '{rrpc_pkg::RADIUS_RST, '0, '1, 30'd1, 30'd3 << rrpc_pkg::FRAC_BITS, '0};
        radii[5] = 30'($urandom);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 6; ph++) begin
            send_idle = (ph < 2) ? 15 : (ph < 4) ? 78 : 0;
            recv_idle = (ph < 2) ? 78 : (ph < 4) ? 15 : 0;
            if (ph > 0) write_radius(radii[ph]);
            if (ph < 3) directed_points();
            if (ph == 2) hold_req = 1'b1;
            random_points(PER_PHASE);
        end
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("%0d points sent over six radius settings, %0d results checked, %0d bad",
                 sent, board.checked, board.mismatches);
        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
